// ===== rtl/plurality_vote_mismatch_report_defines.svh =====
// Assertion helpers for the checker file of the project.
`ifndef PLURALITY_VOTE_MISMATCH_REPORT_DEFINES_SVH
`define PLURALITY_VOTE_MISMATCH_REPORT_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PVMR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion on the block clock and reset.
`define PVMR_ASSERT(label, prop, msg) \
    `PVMR_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/pvmr_pkg.sv =====
`default_nettype none

package pvmr_pkg;

    localparam int MAX_RANKS_DEF = 32;

    localparam int INDEX_W  = 16;
    localparam int HOST_W   = 64;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_AGREE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOTE_RD,
        ST_VOTE_CAP,
        ST_VOTE_SCAN,
        ST_REP_RD,
        ST_REP_CAP,
        ST_REP_SCAN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/plurality_vote_mismatch_report.sv =====
// Plurality vote with mismatch report. Items are loaded one per cycle while
// busy is low; up to MAX_RANKS are stored and further ones only set the
// overflow status. The item with last_item set closes the set and raises busy.
// The block then finds the most common model index (a tie goes to the value
// that appeared first) and emits, in ascending position order, one report per
// mismatching participant that is the first mismatch of its host, then one
// verdict with final_flag set. Every result is shown for a single cycle with
// o_valid and cannot be held off. The stored table sits in one memory pair
// with separate write and read addresses, read one entry per cycle. The vote
// counts, for each stored item, its matches over the whole table, and the
// report walk checks each mismatching position against the positions below
// it. busy drops in the cycle the verdict is shown, and the next set can
// start loading at once.
`default_nettype none

module plurality_vote_mismatch_report #(
    parameter int MAX_RANKS = pvmr_pkg::MAX_RANKS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [pvmr_pkg::INDEX_W-1:0]   i_model_index,
    input  wire logic        [pvmr_pkg::HOST_W-1:0]    i_host_hash,
    input  wire logic                                  i_last_item,
    output logic                                       o_valid,
    output logic                                       o_kind,
    output logic             [pvmr_pkg::POS_W-1:0]     o_position,
    output logic signed      [pvmr_pkg::INDEX_W-1:0]   o_reported_index,
    output logic             [pvmr_pkg::HOST_W-1:0]    o_reported_host,
    output logic signed      [pvmr_pkg::INDEX_W-1:0]   o_reference_index,
    output logic             [pvmr_pkg::COUNT_W-1:0]   o_reference_votes,
    output logic             [pvmr_pkg::COUNT_W-1:0]   o_participant_count,
    output logic             [pvmr_pkg::STATUS_W-1:0]  o_status,
    output logic                                       o_final_flag
);

    localparam int CNT_W  = $clog2(MAX_RANKS + 1);
    localparam int ADDR_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
    localparam logic [CNT_W-1:0] RANKS = CNT_W'(MAX_RANKS);
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

    // Table memories.
    logic [pvmr_pkg::INDEX_W-1:0] index_mem [MAX_RANKS];
    logic [pvmr_pkg::HOST_W-1:0]  host_mem  [MAX_RANKS];
    logic [pvmr_pkg::INDEX_W-1:0] r_rd_index;
    logic [pvmr_pkg::HOST_W-1:0]  r_rd_host;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         mem_we;

    pvmr_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0] r_load_count, n_load_count;
    logic             r_overflow,   n_overflow;
    logic [CNT_W-1:0] r_n,          n_n;
    logic [CNT_W-1:0] r_i,          n_i;
    logic [CNT_W-1:0] r_j,          n_j;
    logic [CNT_W-1:0] r_cnt,        n_cnt;
    logic [CNT_W-1:0] r_best,       n_best;
    logic             r_dup,        n_dup;
    logic [pvmr_pkg::INDEX_W-1:0] r_ref,        n_ref;
    logic [pvmr_pkg::INDEX_W-1:0] r_cand_index, n_cand_index;
    logic [pvmr_pkg::HOST_W-1:0]  r_cand_host,  n_cand_host;

    logic                            r_o_valid,  n_o_valid;
    logic                            r_o_kind,   n_o_kind;
    logic [pvmr_pkg::POS_W-1:0]      r_o_pos,    n_o_pos;
    logic [pvmr_pkg::INDEX_W-1:0]    r_o_ridx,   n_o_ridx;
    logic [pvmr_pkg::HOST_W-1:0]     r_o_rhost,  n_o_rhost;
    logic [pvmr_pkg::INDEX_W-1:0]    r_o_ref,    n_o_ref;
    logic [CNT_W-1:0]                r_o_votes,  n_o_votes;
    logic [CNT_W-1:0]                r_o_count,  n_o_count;
    logic [pvmr_pkg::STATUS_W-1:0]   r_o_status, n_o_status;
    logic                            r_o_final,  n_o_final;

    logic                          accept;
    logic                          has_room;
    logic                          hit;
    logic [CNT_W-1:0]              cnt_sum;
    logic                          dup_sum;
    logic [pvmr_pkg::STATUS_W-1:0] status_now;

    assign busy     = (r_state != pvmr_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign has_room = (r_load_count < RANKS);
    assign mem_we   = accept && has_room;

    assign hit     = (r_rd_index == r_cand_index);
    assign cnt_sum = r_cnt + CNT_W'(hit);
    // A stored entry blocks the candidate when it also mismatches and shares the host.
    assign dup_sum = r_dup || ((r_rd_index != r_ref) && (r_rd_host == r_cand_host));

    assign status_now = r_overflow        ? pvmr_pkg::STATUS_OVERFLOW :
                        (r_best != r_n)   ? pvmr_pkg::STATUS_MISMATCH :
                                            pvmr_pkg::STATUS_AGREE;

    always_comb begin
        unique case (r_state)
            pvmr_pkg::ST_VOTE_RD,
            pvmr_pkg::ST_REP_RD:    rd_addr = r_i[ADDR_W-1:0];
            pvmr_pkg::ST_VOTE_SCAN,
            pvmr_pkg::ST_REP_SCAN:  rd_addr = (r_j < r_n) ? r_j[ADDR_W-1:0] : '0;
            default:                rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            index_mem[r_load_count[ADDR_W-1:0]] <= i_model_index;
            host_mem[r_load_count[ADDR_W-1:0]]  <= i_host_hash;
        end
        r_rd_index <= index_mem[rd_addr];
        r_rd_host  <= host_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pvmr_pkg::ST_IDLE;
            r_load_count <= '0;
            r_overflow   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_overflow   <= n_overflow;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_i          <= n_i;
        r_j          <= n_j;
        r_cnt        <= n_cnt;
        r_best       <= n_best;
        r_dup        <= n_dup;
        r_ref        <= n_ref;
        r_cand_index <= n_cand_index;
        r_cand_host  <= n_cand_host;
        r_o_kind     <= n_o_kind;
        r_o_pos      <= n_o_pos;
        r_o_ridx     <= n_o_ridx;
        r_o_rhost    <= n_o_rhost;
        r_o_ref      <= n_o_ref;
        r_o_votes    <= n_o_votes;
        r_o_count    <= n_o_count;
        r_o_status   <= n_o_status;
        r_o_final    <= n_o_final;
    end

    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_overflow   = r_overflow;
        n_n          = r_n;
        n_i          = r_i;
        n_j          = r_j;
        n_cnt        = r_cnt;
        n_best       = r_best;
        n_dup        = r_dup;
        n_ref        = r_ref;
        n_cand_index = r_cand_index;
        n_cand_host  = r_cand_host;
        n_o_valid    = 1'b0;
        n_o_kind     = r_o_kind;
        n_o_pos      = r_o_pos;
        n_o_ridx     = r_o_ridx;
        n_o_rhost    = r_o_rhost;
        n_o_ref      = r_o_ref;
        n_o_votes    = r_o_votes;
        n_o_count    = r_o_count;
        n_o_status   = r_o_status;
        n_o_final    = r_o_final;

        unique case (r_state)
            pvmr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (has_room) begin
                        n_load_count = r_load_count + ONE;
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_last_item) begin
                        n_n     = has_room ? (r_load_count + ONE) : r_load_count;
                        n_i     = '0;
                        n_best  = '0;
                        n_ref   = '0;
                        n_state = pvmr_pkg::ST_VOTE_RD;
                    end
                end
            end

            pvmr_pkg::ST_VOTE_RD: begin
                n_state = pvmr_pkg::ST_VOTE_CAP;
            end

            pvmr_pkg::ST_VOTE_CAP: begin
                n_cand_index = r_rd_index;
                n_j          = ONE;
                n_cnt        = '0;
                n_state      = pvmr_pkg::ST_VOTE_SCAN;
            end

            // Counts every entry equal to the candidate; later copies of a value
            // give the same count and lose the strict compare, so ties keep the
            // earliest first occurrence.
            pvmr_pkg::ST_VOTE_SCAN: begin
                if (r_j == r_n) begin
                    if (cnt_sum > r_best) begin
                        n_best = cnt_sum;
                        n_ref  = r_cand_index;
                    end
                    if ((r_i + ONE) == r_n) begin
                        n_i     = '0;
                        n_state = pvmr_pkg::ST_REP_RD;
                    end else begin
                        n_i     = r_i + ONE;
                        n_state = pvmr_pkg::ST_VOTE_RD;
                    end
                end else begin
                    n_j   = r_j + ONE;
                    n_cnt = cnt_sum;
                end
            end

            pvmr_pkg::ST_REP_RD: begin
                if (r_i == r_n) begin
                    n_o_valid    = 1'b1;
                    n_o_kind     = pvmr_pkg::KIND_VERDICT;
                    n_o_pos      = '0;
                    n_o_ridx     = '0;
                    n_o_rhost    = '0;
                    n_o_ref      = r_ref;
                    n_o_votes    = r_best;
                    n_o_count    = r_n;
                    n_o_status   = status_now;
                    n_o_final    = 1'b1;
                    n_load_count = '0;
                    n_overflow   = 1'b0;
                    n_state      = pvmr_pkg::ST_IDLE;
                end else begin
                    n_state = pvmr_pkg::ST_REP_CAP;
                end
            end

            pvmr_pkg::ST_REP_CAP: begin
                n_cand_index = r_rd_index;
                n_cand_host  = r_rd_host;
                if (r_rd_index == r_ref) begin
                    n_i     = r_i + ONE;
                    n_state = pvmr_pkg::ST_REP_RD;
                end else if (r_i == '0) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = pvmr_pkg::KIND_REPORT;
                    n_o_pos    = pvmr_pkg::POS_W'(r_i);
                    n_o_ridx   = r_rd_index;
                    n_o_rhost  = r_rd_host;
                    n_o_ref    = r_ref;
                    n_o_votes  = r_best;
                    n_o_count  = r_n;
                    n_o_status = status_now;
                    n_o_final  = 1'b0;
                    n_i        = r_i + ONE;
                    n_state    = pvmr_pkg::ST_REP_RD;
                end else begin
                    n_j     = ONE;
                    n_dup   = 1'b0;
                    n_state = pvmr_pkg::ST_REP_SCAN;
                end
            end

            // The data on the read port belongs to position r_j - 1.
            pvmr_pkg::ST_REP_SCAN: begin
                if (r_j == r_i) begin
                    if (!dup_sum) begin
                        n_o_valid  = 1'b1;
                        n_o_kind   = pvmr_pkg::KIND_REPORT;
                        n_o_pos    = pvmr_pkg::POS_W'(r_i);
                        n_o_ridx   = r_cand_index;
                        n_o_rhost  = r_cand_host;
                        n_o_ref    = r_ref;
                        n_o_votes  = r_best;
                        n_o_count  = r_n;
                        n_o_status = status_now;
                        n_o_final  = 1'b0;
                    end
                    n_i     = r_i + ONE;
                    n_state = pvmr_pkg::ST_REP_RD;
                end else begin
                    n_j   = r_j + ONE;
                    n_dup = dup_sum;
                end
            end

            default: begin
                n_state = pvmr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid             = r_o_valid;
    assign o_kind              = r_o_kind;
    assign o_position          = r_o_pos;
    assign o_reported_index    = $signed(r_o_ridx);
    assign o_reported_host     = r_o_rhost;
    assign o_reference_index   = $signed(r_o_ref);
    assign o_reference_votes   = pvmr_pkg::COUNT_W'(r_o_votes);
    assign o_participant_count = pvmr_pkg::COUNT_W'(r_o_count);
    assign o_status            = r_o_status;
    assign o_final_flag        = r_o_final;

endmodule

`default_nettype wire

// ===== rtl/pvmr_checker.sv =====
`default_nettype none

`include "plurality_vote_mismatch_report_defines.svh"

module pvmr_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  start,
    input wire logic                                  busy,
    input wire logic                                  i_last_item,
    input wire logic                                  o_valid,
    input wire logic                                  o_kind,
    input wire logic signed [pvmr_pkg::INDEX_W-1:0]   o_reported_index,
    input wire logic signed [pvmr_pkg::INDEX_W-1:0]   o_reference_index,
    input wire logic        [pvmr_pkg::COUNT_W-1:0]   o_reference_votes,
    input wire logic        [pvmr_pkg::COUNT_W-1:0]   o_participant_count,
    input wire logic        [pvmr_pkg::STATUS_W-1:0]  o_status,
    input wire logic                                  o_final_flag
);

    // The closing beat of a set always starts an evaluation.
    `PVMR_ASSERT(a_last_starts_eval, (start && !busy && i_last_item) |=> busy, "last beat did not raise busy")

    // Only the verdict carries the final flag.
    `PVMR_ASSERT(a_final_is_verdict, o_valid |-> ((o_kind == pvmr_pkg::KIND_VERDICT) == o_final_flag), "final flag and kind disagree")

    // A report always names an index other than the reference and comes before busy drops.
    `PVMR_ASSERT(a_report_mismatch, (o_valid && (o_kind == pvmr_pkg::KIND_REPORT)) |-> (busy && (o_reported_index != o_reference_index)), "bad mismatch report")

    // An agreeing verdict means every participant voted for the reference.
    `PVMR_ASSERT(a_agree_votes, (o_valid && o_final_flag && (o_status == pvmr_pkg::STATUS_AGREE)) |-> (o_reference_votes == o_participant_count), "agree verdict with missing votes")

endmodule

bind plurality_vote_mismatch_report pvmr_checker u_pvmr_checker (.*);

`default_nettype wire

// ===== tb/tb_plurality_vote_mismatch_report.sv =====
`timescale 1ns / 1ps

module tb_plurality_vote_mismatch_report;

    localparam int INDEX_W  = pvmr_pkg::INDEX_W;
    localparam int HOST_W   = pvmr_pkg::HOST_W;
    localparam int POS_W    = pvmr_pkg::POS_W;
    localparam int COUNT_W  = pvmr_pkg::COUNT_W;
    localparam int STATUS_W = pvmr_pkg::STATUS_W;

    localparam int RANKS       = pvmr_pkg::MAX_RANKS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 380;

    typedef struct packed {
        logic                kind;
        logic [POS_W-1:0]    position;
        logic [INDEX_W-1:0]  reported_index;
        logic [HOST_W-1:0]   reported_host;
        logic [INDEX_W-1:0]  reference_index;
        logic [COUNT_W-1:0]  reference_votes;
        logic [COUNT_W-1:0]  participant_count;
        logic [STATUS_W-1:0] status;
        logic                final_flag;
    } t_vote_result;

    // One directed row is repeated reps times; the verdict is typed in only
    // where the row is marked as fixed.
    typedef struct packed {
        logic [INDEX_W-1:0]  idx;
        logic [HOST_W-1:0]   host;
        logic                closing;
        logic [7:0]          reps;
        logic                fixed;
        logic [INDEX_W-1:0]  ref_idx;
        logic [COUNT_W-1:0]  votes;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_plan_row;

    localparam logic [HOST_W-1:0] H_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [HOST_W-1:0] H_B = 64'hFEDC_BA98_7654_3210;
    localparam logic [HOST_W-1:0] H_C = 64'h8000_0000_0000_0001;
    localparam logic [HOST_W-1:0] H_D = 64'h5A5A_A5A5_0F0F_F0F0;

    localparam int PLAN_ROWS = 23;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // Single participants at both ends of the index range.
        '{16'h8000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd1, 1'b1, 16'h8000, 7'd1, 7'd1,
          pvmr_pkg::STATUS_AGREE},
        '{16'h7FFF, 64'h0, 1'b1, 8'd1, 1'b1, 16'h7FFF, 7'd1, 7'd1,
          pvmr_pkg::STATUS_AGREE},
        // Three participants that agree.
        '{16'h0000, 64'h1, 1'b0, 8'd2, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'h0000, 64'h2, 1'b1, 8'd1, 1'b1, 16'h0, 7'd3, 7'd3, pvmr_pkg::STATUS_AGREE},
        // Two against two: the value seen first wins the tie.
        '{16'd5, H_A, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd7, H_B, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd7, H_C, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd5, H_D, 1'b1, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        // Several mismatches on one host are reported once, at the lowest one.
        '{16'd1, H_A, 1'b0, 8'd3, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd2, H_B, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd1, H_B, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd3, H_B, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd4, H_C, 1'b1, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        // Everyone differs.
        '{16'hFFFF, H_A, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'hFFFE, H_A, 1'b0, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'hFFFD, H_B, 1'b1, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        // Exactly full, no overflow.
        '{16'd9, H_A, 1'b0, 8'd31, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd9, H_B, 1'b1, 8'd1, 1'b1, 16'd9, 7'd32, 7'd32, pvmr_pkg::STATUS_AGREE},
        // One past capacity: the closing item itself is dropped.
        '{16'd100, H_C, 1'b0, 8'd32, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'hFFFF, H_D, 1'b1, 8'd1, 1'b1, 16'd100, 7'd32, 7'd32,
          pvmr_pkg::STATUS_OVERFLOW},
        // Overflow with mismatches still reports them.
        '{16'd6, H_A, 1'b0, 8'd20, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'hFFFA, H_B, 1'b0, 8'd14, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE},
        '{16'd6, H_C, 1'b1, 8'd1, 1'b0, 16'h0, 7'd0, 7'd0, pvmr_pkg::STATUS_AGREE}
    };

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [INDEX_W-1:0] i_model_index = '0;
    logic [HOST_W-1:0]         i_host_hash = '0;
    logic                      i_last_item = 1'b0;
    logic                      o_valid;
    logic                      o_kind;
    logic [POS_W-1:0]          o_position;
    logic signed [INDEX_W-1:0] o_reported_index;
    logic [HOST_W-1:0]         o_reported_host;
    logic signed [INDEX_W-1:0] o_reference_index;
    logic [COUNT_W-1:0]        o_reference_votes;
    logic [COUNT_W-1:0]        o_participant_count;
    logic [STATUS_W-1:0]       o_status;
    logic                      o_final_flag;

    plurality_vote_mismatch_report u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_model_index       (i_model_index),
        .i_host_hash         (i_host_hash),
        .i_last_item         (i_last_item),
        .o_valid             (o_valid),
        .o_kind              (o_kind),
        .o_position          (o_position),
        .o_reported_index    (o_reported_index),
        .o_reported_host     (o_reported_host),
        .o_reference_index   (o_reference_index),
        .o_reference_votes   (o_reference_votes),
        .o_participant_count (o_participant_count),
        .o_status            (o_status),
        .o_final_flag        (o_final_flag)
    );

    // Shadow of the participant table.
    logic [INDEX_W-1:0] idx_tbl [RANKS];
    logic [HOST_W-1:0]  host_tbl [RANKS];
    int                 loaded = 0;
    bit                 overran = 1'b0;

    t_vote_result report_queue [$];

    int  error_count = 0;
    int  items_sent = 0;
    int  sets_sent = 0;
    int  overflow_sets = 0;
    int  reports_seen = 0;
    int  verdicts_seen = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stores one participant and, when it closes the set, queues the reports
    // and the verdict that the vote yields.
    task automatic absorb_participant(input logic [INDEX_W-1:0] idx,
                                      input logic [HOST_W-1:0] host, input bit closing);
        int                  best;
        int                  cnt;
        logic [INDEX_W-1:0]  ref_idx;
        bit                  first_seen;
        bit                  mismatch;
        bit                  lowest;
        logic [STATUS_W-1:0] st;
        t_vote_result        res;
        if (loaded < RANKS) begin
            idx_tbl[loaded] = idx;
            host_tbl[loaded] = host;
            loaded++;
        end else begin
            overran = 1'b1;
        end
        if (!closing) return;

        best = 0;
        ref_idx = '0;
        mismatch = 1'b0;
        for (int i = 0; i < loaded; i++) begin
            first_seen = 1'b1;
            for (int j = 0; j < i; j++)
                if (idx_tbl[j] == idx_tbl[i]) first_seen = 1'b0;
            if (first_seen) begin
                cnt = 0;
                for (int j = i; j < loaded; j++)
                    if (idx_tbl[j] == idx_tbl[i]) cnt++;
                if (cnt > best) begin
                    best = cnt;
                    ref_idx = idx_tbl[i];
                end
            end
        end
        for (int i = 0; i < loaded; i++)
            if (idx_tbl[i] != ref_idx) mismatch = 1'b1;
        st = overran ? pvmr_pkg::STATUS_OVERFLOW :
             (mismatch ? pvmr_pkg::STATUS_MISMATCH : pvmr_pkg::STATUS_AGREE);

        for (int i = 0; i < loaded; i++) begin
            if (idx_tbl[i] != ref_idx) begin
                lowest = 1'b1;
                for (int j = 0; j < i; j++)
                    if (idx_tbl[j] != ref_idx && host_tbl[j] == host_tbl[i]) lowest = 1'b0;
                if (lowest) begin
                    res = '{kind: pvmr_pkg::KIND_REPORT, position: POS_W'(i),
                            reported_index: idx_tbl[i], reported_host: host_tbl[i],
                            reference_index: ref_idx, reference_votes: COUNT_W'(best),
                            participant_count: COUNT_W'(loaded), status: st,
                            final_flag: 1'b0};
                    report_queue.push_back(res);
                end
            end
        end
        res = '{kind: pvmr_pkg::KIND_VERDICT, position: '0, reported_index: '0,
                reported_host: '0, reference_index: ref_idx,
                reference_votes: COUNT_W'(best), participant_count: COUNT_W'(loaded),
                status: st, final_flag: 1'b1};
        report_queue.push_back(res);

        sets_sent++;
        if (overran) overflow_sets++;
        loaded = 0;
        overran = 1'b0;
    endtask

    // Presents one item until it is taken, then may idle for a random gap.
    task automatic put_item(input logic [INDEX_W-1:0] idx, input logic [HOST_W-1:0] host,
                            input bit closing, input bit fixed,
                            input t_vote_result fixed_verdict);
        int gap;
        int r;
        start <= 1'b1;
        i_model_index <= idx;
        i_host_hash <= host;
        i_last_item <= closing;
        do @(posedge i_clk); while (busy);
        absorb_participant(idx, host, closing);
        items_sent++;
        if (fixed) begin
            report_queue.delete(report_queue.size() - 1);
            report_queue.push_back(fixed_verdict);
        end
        r = $urandom_range(0, 99);
        if (quiet || r < 60) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_random_set();
        logic [INDEX_W-1:0] idx_pool [4];
        logic [HOST_W-1:0]  host_pool [4];
        logic [INDEX_W-1:0] idx;
        logic [HOST_W-1:0]  host;
        int                 n;
        int                 n_idx;
        int                 n_host;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 70) n = $urandom_range(1, 8);
        else if (r < 92) n = $urandom_range(9, RANKS - 1);
        else n = $urandom_range(RANKS, RANKS + 4);
        n_idx = $urandom_range(1, 4);
        n_host = $urandom_range(1, 4);
        quiet = ($urandom_range(0, 3) == 0);
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(0, 7))
                0: idx_pool[p] = 16'h8000;
                1: idx_pool[p] = 16'h7FFF;
                2: idx_pool[p] = 16'h0000;
                3: idx_pool[p] = 16'hFFFF;
                default: idx_pool[p] = INDEX_W'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0: host_pool[p] = '1;
                1: host_pool[p] = '0;
                default: host_pool[p] = {$urandom, $urandom};
            endcase
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) idx = INDEX_W'($urandom);
            else idx = idx_pool[$urandom_range(0, n_idx - 1)];
            if ($urandom_range(0, 7) == 0) host = {$urandom, $urandom};
            else host = host_pool[$urandom_range(0, n_host - 1)];
            put_item(idx, host, k == n - 1, 1'b0, '0);
        end
    endtask

    function automatic void check_field(string name, logic [HOST_W-1:0] want,
                                        logic [HOST_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_vote_result want;
        if (i_rst_n && o_valid) begin
            if (report_queue.size() == 0) begin
                $error("result beat with nothing pending: kind %0d position %0d",
                       o_kind, o_position);
                error_count++;
            end else begin
                want = report_queue.pop_front();
                check_field("kind", HOST_W'(want.kind), HOST_W'(o_kind));
                check_field("position", HOST_W'(want.position), HOST_W'(o_position));
                check_field("reported_index", HOST_W'(want.reported_index),
                            HOST_W'($unsigned(o_reported_index)));
                check_field("reported_host", want.reported_host, o_reported_host);
                check_field("reference_index", HOST_W'(want.reference_index),
                            HOST_W'($unsigned(o_reference_index)));
                check_field("reference_votes", HOST_W'(want.reference_votes),
                            HOST_W'(o_reference_votes));
                check_field("participant_count", HOST_W'(want.participant_count),
                            HOST_W'(o_participant_count));
                check_field("status", HOST_W'(want.status), HOST_W'(o_status));
                check_field("final_flag", HOST_W'(want.final_flag), HOST_W'(o_final_flag));
                if (want.kind == pvmr_pkg::KIND_VERDICT) verdicts_seen++;
                else reports_seen++;
            end
        end
    end

    initial begin
        t_vote_result fv;
        bit           closing;
        int           random_base;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_ROWS; r++) begin
            for (int k = 0; k < int'(PLAN[r].reps); k++) begin
                closing = PLAN[r].closing && (k == int'(PLAN[r].reps) - 1);
                fv = '{kind: pvmr_pkg::KIND_VERDICT, position: '0, reported_index: '0,
                       reported_host: '0, reference_index: PLAN[r].ref_idx,
                       reference_votes: PLAN[r].votes, participant_count: PLAN[r].count,
                       status: PLAN[r].status, final_flag: 1'b1};
                put_item(PLAN[r].idx, PLAN[r].host, closing, closing && PLAN[r].fixed, fv);
            end
        end

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
            run_random_set();
        start <= 1'b0;

        while (report_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Loaded %0d participants in %0d sets, %0d of them past capacity.",
                 items_sent, sets_sent, overflow_sets);
        $display("Checked %0d mismatch reports and %0d verdicts.",
                 reports_seen, verdicts_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pvmr_pkg.sv
rtl/plurality_vote_mismatch_report.sv
rtl/pvmr_checker.sv
tb/tb_plurality_vote_mismatch_report.sv
